// File: src/base_relocation_block_parser_unit_macros.svh
// Assertion macros shared by the checker of the relocation parser.
`ifndef BASE_RELOCATION_BLOCK_PARSER_UNIT_MACROS_SVH
`define BASE_RELOCATION_BLOCK_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRBP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("relocation parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("relocation parser check failed");

`endif

// File: src/brbp_pkg.sv
package brbp_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] reloc_rva;
  } out_item_t;

  typedef struct packed {
    logic        parse_enable;
    logic [15:0] directory_size;
    logic [15:0] available_bytes;
  } cfg_t;

  typedef struct packed {
    logic        rel_valid;
    logic        end_valid;
    logic [31:0] rva;
  } push_t;

  typedef enum logic [1:0] {
    REG_PARSE_ENABLE    = 2'd0,
    REG_DIRECTORY_SIZE  = 2'd1,
    REG_AVAILABLE_BYTES = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_PAGE_LO  = 3'd0,
    PH_PAGE_HI  = 3'd1,
    PH_SIZE_LO  = 3'd2,
    PH_SIZE_HI  = 3'd3,
    PH_ENTRIES  = 3'd4
  } phase_t;

  localparam logic        KIND_DATA    = 1'b0;
  localparam logic        KIND_START   = 1'b1;
  localparam logic        RESULT_RELOC = 1'b0;
  localparam logic        RESULT_END   = 1'b1;

  localparam logic [15:0] TYPE_MASK    = 16'hF000;
  localparam logic [15:0] TYPE_DIR64   = 16'hA000;
  localparam logic [15:0] OFFSET_MASK  = 16'h0FFF;
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

endpackage

// File: src/base_relocation_block_parser_unit.sv
// An accepted item is first held in the input register; its results are then
// written into the result queue, from which they can be taken.
// Throughput: one item per cycle; the input stalls while more than two results
// wait in the four-entry result queue, since one item can add two results.
// Reset is synchronous and active high; it clears the control state and leaves
// the parser finished, so data items are ignored until a start item.
module base_relocation_block_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  brbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brbp_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import brbp_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  space;

  brbp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brbp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .space    (space),
    .push     (push)
  );

  brbp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/brbp_cfg.sv
module brbp_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output brbp_pkg::cfg_t cfg
);
  import brbp_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PARSE_ENABLE:    cfg.parse_enable    <= pwdata[0];
        REG_DIRECTORY_SIZE:  cfg.directory_size  <= pwdata[15:0];
        REG_AVAILABLE_BYTES: cfg.available_bytes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PARSE_ENABLE:    prdata = {31'd0, cfg.parse_enable};
      REG_DIRECTORY_SIZE:  prdata = {16'd0, cfg.directory_size};
      REG_AVAILABLE_BYTES: prdata = {16'd0, cfg.available_bytes};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// File: src/brbp_core.sv
module brbp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  brbp_pkg::in_item_t in_data,
  input  brbp_pkg::cfg_t     cfg,
  input  logic               space,
  output brbp_pkg::push_t    push
);
  import brbp_pkg::*;

  logic        in_valid_q;
  in_item_t    in_q;
  logic        step;

  phase_t      phase, phase_next;
  logic [31:0] page_address, page_address_next;
  logic [31:0] block_bytes, block_bytes_next;
  logic [30:0] entries_left, entries_left_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic        finished, finished_next;

  logic [15:0] word;
  logic        is_start, active, disable_end, start_end;
  logic [31:0] size_full, blk_sel, size_less;
  logic        hdr_bad;
  logic [30:0] el_hdr, el_dec;
  logic [15:0] off_new;
  logic        off_inside, hdr_blk_end, ent, ent_blk_end, blk_end;

  assign step     = in_valid_q && space;
  assign in_ready = !in_valid_q || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  assign word        = in_q.data_word;
  assign is_start    = in_q.kind == KIND_START;
  assign active      = step && !is_start && !finished && cfg.parse_enable;
  assign disable_end = step && !is_start && !finished && !cfg.parse_enable;
  assign start_end   = !(cfg.parse_enable && cfg.directory_size != 16'd0 &&
                         cfg.available_bytes != 16'd0);

  assign size_full   = {word, block_bytes[15:0]};
  assign hdr_bad     = size_full == 32'd0 || page_address == 32'd0;
  assign size_less   = size_full - HEADER_BYTES;
  assign el_hdr      = (size_full < HEADER_BYTES) ? 31'd0 : size_less[31:1];
  assign el_dec      = (entries_left != 31'd0) ? entries_left - 31'd1 : entries_left;
  assign blk_sel     = (phase == PH_SIZE_HI) ? size_full : block_bytes;
  assign off_new     = byte_offset + {blk_sel[15:1], 1'b0};
  assign off_inside  = off_new < cfg.directory_size && off_new < cfg.available_bytes;

  assign hdr_blk_end = active && phase == PH_SIZE_HI && !hdr_bad && el_hdr == 31'd0;
  assign ent         = active && phase == PH_ENTRIES;
  assign ent_blk_end = ent && el_dec == 31'd0;
  assign blk_end     = hdr_blk_end || ent_blk_end;

  always_comb begin
    phase_next        = phase;
    page_address_next = page_address;
    block_bytes_next  = block_bytes;
    entries_left_next = entries_left;
    byte_offset_next  = byte_offset;
    finished_next     = finished;
    if (step && is_start) begin
      phase_next        = PH_PAGE_LO;
      page_address_next = 32'd0;
      block_bytes_next  = 32'd0;
      entries_left_next = 31'd0;
      byte_offset_next  = 16'd0;
      finished_next     = start_end;
    end else if (active) begin
      case (phase)
        PH_PAGE_LO: begin
          page_address_next = {16'd0, word};
          phase_next        = PH_PAGE_HI;
        end
        PH_PAGE_HI: begin
          page_address_next = {word, page_address[15:0]};
          phase_next        = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          block_bytes_next = {16'd0, word};
          phase_next       = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          block_bytes_next = size_full;
          if (hdr_bad) begin
            finished_next = 1'b1;
          end else begin
            entries_left_next = el_hdr;
            if (el_hdr != 31'd0) begin
              phase_next = PH_ENTRIES;
            end
          end
        end
        default: begin
          entries_left_next = el_dec;
        end
      endcase
      if (blk_end) begin
        byte_offset_next = off_new;
        if (off_inside) begin
          phase_next = PH_PAGE_LO;
        end else begin
          finished_next = 1'b1;
        end
      end
    end else if (disable_end) begin
      finished_next = 1'b1;
    end
  end

  always_comb begin
    push.rel_valid = ent && (word & TYPE_MASK) == TYPE_DIR64;
    push.rva       = page_address + {20'd0, word[11:0] & OFFSET_MASK[11:0]};
    push.end_valid = (step && is_start && start_end) || disable_end ||
                     (active && phase == PH_SIZE_HI && hdr_bad) ||
                     (blk_end && !off_inside);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PAGE_LO;
      page_address <= 32'd0;
      block_bytes  <= 32'd0;
      entries_left <= 31'd0;
      byte_offset  <= 16'd0;
      finished     <= 1'b1;
    end else begin
      phase        <= phase_next;
      page_address <= page_address_next;
      block_bytes  <= block_bytes_next;
      entries_left <= entries_left_next;
      byte_offset  <= byte_offset_next;
      finished     <= finished_next;
    end
  end

endmodule

// File: src/brbp_fifo.sv
module brbp_fifo (
  input  logic                clk,
  input  logic                rst,
  input  brbp_pkg::push_t     push,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output brbp_pkg::out_item_t out_data
);
  import brbp_pkg::*;

  out_item_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr, end_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;
  logic [FIFO_CW-1:0]   push_n;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign space     = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign push_n    = FIFO_CW'(push.rel_valid) + FIFO_CW'(push.end_valid);
  assign end_ptr   = push.rel_valid ? wr_ptr + FIFO_AW'(1) : wr_ptr;

  always_ff @(posedge clk) begin
    if (push.rel_valid) begin
      mem[wr_ptr] <= '{result_kind: RESULT_RELOC, reloc_rva: push.rva};
    end
    if (push.end_valid) begin
      mem[end_ptr] <= '{result_kind: RESULT_END, reloc_rva: 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[FIFO_AW-1:0];
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count + push_n - FIFO_CW'(pop);
    end
  end

endmodule

// File: src/brbp_checker.sv
`include "base_relocation_block_parser_unit_macros.svh"

module brbp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input brbp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input brbp_pkg::out_item_t out_data,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [3:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);
  import brbp_pkg::*;

  logic en_write;
  logic en_read;
  logic end_out;

  assign en_write = psel && penable && pwrite && pready && paddr[3:2] == REG_PARSE_ENABLE;
  assign en_read  = paddr[3:2] == REG_PARSE_ENABLE;
  assign end_out  = out_valid && out_data.result_kind == RESULT_END;

  // A stalled result item keeps its place and its value.
  `BRBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A waiting input item keeps its place and its value.
  `BRBP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

  // An end item never carries an address.
  `BRBP_ASSERT_SAME(a_end_zero, end_out, out_data.reloc_rva == 32'd0)

  // With no result pending the input side can never be blocked.
  `BRBP_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

  // A write to the enable register is visible on a read of it in the next cycle.
  `BRBP_ASSERT_NEXT(a_enable_readback, en_write, !en_read || prdata[0] == $past(pwdata[0]))

endmodule

bind base_relocation_block_parser_unit brbp_checker u_brbp_checker (.*);
